### rtl/vpts_pkg.sv
package vpts_pkg;

  // field and datapath widths
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned CoordFrac  = 16;
  localparam int unsigned EntryWidth = 16;
  localparam int unsigned ProdWidth  = EntryWidth + CoordWidth;
  localparam int unsigned ClipWidth  = ProdWidth + 2;
  localparam int unsigned NumWidth   = ClipWidth + 1;
  localparam int unsigned MagWidth   = NumWidth - 1;
  localparam int unsigned DivWidth   = ClipWidth - 1;
  localparam int unsigned QuotBits   = CoordWidth + 1;
  localparam int unsigned LowBits    = QuotBits - (CoordFrac - 1);
  localparam int unsigned CapWidth   = QuotBits + 1;
  localparam int unsigned ViewWidth  = 16;
  localparam int unsigned ScaledWidth = CapWidth + ViewWidth;
  localparam int unsigned ScrWidth   = ScaledWidth + 2;

  // pipeline layout
  localparam int unsigned DivBase   = 4;
  localparam int unsigned MulStage  = DivBase + QuotBits + 1;
  localparam int unsigned NumStages = MulStage + 2;

  localparam int unsigned CfgAddrWidth = 6;
  localparam int unsigned CfgDataWidth = 64;

  typedef enum logic [2:0] {
    RegRow0    = 3'd0,
    RegRow1    = 3'd1,
    RegRow2    = 3'd2,
    RegRow3    = 3'd3,
    RegOffsetX = 3'd4,
    RegOffsetY = 3'd5,
    RegScaleX  = 3'd6,
    RegScaleY  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [DivWidth-1:0] rem;
    logic [QuotBits-1:0] quot;
    logic [LowBits-1:0]  low;
    logic                neg;
    logic                big;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]     lane;
    logic [DivWidth-1:0] dm;
    logic                winv;
  } div_stage_t;

  typedef struct packed {
    logic                  sat;
    logic [CoordWidth-1:0] val;
  } sat_res_t;

  // one restoring step per lane: bring in the next numerator bit
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t        o;
    logic [DivWidth:0] pre;
    logic              ge;
    o = s;
    for (int i = 0; i < 3; i++) begin
      pre = {s.lane[i].rem, s.lane[i].low[LowBits-1]};
      ge  = (pre >= {1'b0, s.dm});
      o.lane[i].rem  = ge ? DivWidth'(pre - {1'b0, s.dm}) : DivWidth'(pre);
      o.lane[i].quot = {s.lane[i].quot[QuotBits-2:0], ge};
      o.lane[i].low  = {s.lane[i].low[LowBits-2:0], 1'b0};
    end
    return o;
  endfunction

  // clamp to the signed coordinate range
  function automatic sat_res_t sat_coord(input logic signed [ScrWidth-1:0] v);
    sat_res_t                          r;
    logic [ScrWidth-CoordWidth:0]      top;
    top   = v[ScrWidth-1:CoordWidth-1];
    r.sat = !((&top) || !(|top));
    r.val = r.sat ? {v[ScrWidth-1], {(CoordWidth-1){~v[ScrWidth-1]}}}
                  : v[CoordWidth-1:0];
    return r;
  endfunction

endpackage

### rtl/vertex_project_to_screen.sv
// channel  | handshake                     | payload
// ---------+-------------------------------+---------------------------------------
// input    | in_valid_i / in_ready_o       | coord_x_i, coord_y_i, coord_z_i
// output   | out_valid_o / out_ready_i     | screen_x_o, screen_y_o, depth_o,
//          |                               | w_invalid_o, saturated_o
// config   | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata (64 bit)
//
// one request enters per cycle while in_ready_o is high; 40 register stages,
// most of them in the 33-step restoring divider (one quotient bit per stage)
// each stage moves on when it is empty or its successor moves, so bubbles close
// up and a stalled output still lets upstream stages fill
// reset clears valid bits and loads the identity matrix and zero viewport
module vertex_project_to_screen (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [vpts_pkg::CfgAddrWidth-1:0]      paddr,
  input  logic [vpts_pkg::CfgDataWidth-1:0]      pwdata,
  output logic [vpts_pkg::CfgDataWidth-1:0]      prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [vpts_pkg::CoordWidth-1:0] coord_x_i,
  input  logic signed [vpts_pkg::CoordWidth-1:0] coord_y_i,
  input  logic signed [vpts_pkg::CoordWidth-1:0] coord_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [vpts_pkg::CoordWidth-1:0] screen_x_o,
  output logic signed [vpts_pkg::CoordWidth-1:0] screen_y_o,
  output logic signed [vpts_pkg::CoordWidth-1:0] depth_o,
  output logic                                   w_invalid_o,
  output logic                                   saturated_o
);

  localparam int unsigned NS = vpts_pkg::NumStages;
  localparam int unsigned QB = vpts_pkg::QuotBits;
  localparam int unsigned DB = vpts_pkg::DivBase;
  localparam int unsigned MS = vpts_pkg::MulStage;

  // ---------------------------------------------------------------- registers
  logic [3:0][vpts_pkg::CfgDataWidth-1:0] matrix_q;
  logic [vpts_pkg::ViewWidth-1:0]         off_x_q, off_y_q, scale_x_q, scale_y_q;
  logic                                   cfg_wr;
  vpts_pkg::reg_idx_e                     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = vpts_pkg::reg_idx_e'(paddr[vpts_pkg::CfgAddrWidth-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q[0] <= 64'h0000_0000_0000_1000;
      matrix_q[1] <= 64'h0000_0000_1000_0000;
      matrix_q[2] <= 64'h0000_1000_0000_0000;
      matrix_q[3] <= 64'h1000_0000_0000_0000;
      off_x_q     <= '0;
      off_y_q     <= '0;
      scale_x_q   <= '0;
      scale_y_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vpts_pkg::RegRow0:    matrix_q[0] <= pwdata;
        vpts_pkg::RegRow1:    matrix_q[1] <= pwdata;
        vpts_pkg::RegRow2:    matrix_q[2] <= pwdata;
        vpts_pkg::RegRow3:    matrix_q[3] <= pwdata;
        vpts_pkg::RegOffsetX: off_x_q     <= pwdata[vpts_pkg::ViewWidth-1:0];
        vpts_pkg::RegOffsetY: off_y_q     <= pwdata[vpts_pkg::ViewWidth-1:0];
        vpts_pkg::RegScaleX:  scale_x_q   <= pwdata[vpts_pkg::ViewWidth-1:0];
        vpts_pkg::RegScaleY:  scale_y_q   <= pwdata[vpts_pkg::ViewWidth-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      vpts_pkg::RegRow0:    prdata = matrix_q[0];
      vpts_pkg::RegRow1:    prdata = matrix_q[1];
      vpts_pkg::RegRow2:    prdata = matrix_q[2];
      vpts_pkg::RegRow3:    prdata = matrix_q[3];
      vpts_pkg::RegOffsetX: prdata = vpts_pkg::CfgDataWidth'(off_x_q);
      vpts_pkg::RegOffsetY: prdata = vpts_pkg::CfgDataWidth'(off_y_q);
      vpts_pkg::RegScaleX:  prdata = vpts_pkg::CfgDataWidth'(scale_x_q);
      vpts_pkg::RegScaleY:  prdata = vpts_pkg::CfgDataWidth'(scale_y_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- flow control
  // adv[k]: stage k loads from stage k-1 this cycle
  logic [NS-1:0] valid_q, adv;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // ------------------------------------------------------ stage 0: capture
  logic signed [vpts_pkg::CoordWidth-1:0] vec_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      vec_q[0] <= coord_x_i;
      vec_q[1] <= coord_y_i;
      vec_q[2] <= coord_z_i;
    end
  end

  // matrix entries, column j at bits 16j
  logic signed [vpts_pkg::EntryWidth-1:0] ent [4][4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        ent[r][j] = matrix_q[r][vpts_pkg::EntryWidth*j +: vpts_pkg::EntryWidth];
      end
    end
  end

  // ----------------------------------------------------- stage 1: products
  // 16x32 signed products are exact and stay far inside the clamp limit
  logic signed [vpts_pkg::ProdWidth-1:0] prod_q [4][3];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[r][j] <= vpts_pkg::ProdWidth'(ent[r][j]) *
                          vpts_pkg::ProdWidth'(vec_q[j]);
        end
      end
    end
  end

  // ---------------------------------------------------- stage 2: row sums
  // w component of the vertex is one in Q16.16
  logic signed [vpts_pkg::ClipWidth-1:0] clip_q [4];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int r = 0; r < 4; r++) begin
        clip_q[r] <= vpts_pkg::ClipWidth'(prod_q[r][0]) +
                     vpts_pkg::ClipWidth'(prod_q[r][1]) +
                     vpts_pkg::ClipWidth'(prod_q[r][2]) +
                     (vpts_pkg::ClipWidth'(ent[r][3]) <<< vpts_pkg::CoordFrac);
      end
    end
  end

  // ------------------------------------- stage 3: numerators and magnitudes
  logic [vpts_pkg::MagWidth-1:0]  nm_q [3];
  logic [2:0]                     neg_q;
  logic [vpts_pkg::DivWidth-1:0]  dm_q;
  logic                           winv_q;

  logic signed [vpts_pkg::NumWidth-1:0] num_c [3];
  logic signed [vpts_pkg::ClipWidth-1:0] w_c;

  always_comb begin
    w_c = clip_q[3];
    for (int i = 0; i < 3; i++) begin
      num_c[i] = vpts_pkg::NumWidth'(clip_q[i]) + vpts_pkg::NumWidth'(w_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        nm_q[i]  <= num_c[i][vpts_pkg::NumWidth-1] ? vpts_pkg::MagWidth'(-num_c[i])
                                                   : vpts_pkg::MagWidth'(num_c[i]);
        neg_q[i] <= num_c[i][vpts_pkg::NumWidth-1] ^ w_c[vpts_pkg::ClipWidth-1];
      end
      dm_q   <= w_c[vpts_pkg::ClipWidth-1] ? vpts_pkg::DivWidth'(-w_c)
                                           : vpts_pkg::DivWidth'(w_c);
      winv_q <= (w_c == '0);
    end
  end

  // ------------------------------------------- stage 4: divider set-up
  // the quotient reaches 2^33 exactly when the upper numerator bits reach |w|;
  // beyond that the lane is only flagged, and its magnitude is capped at 2^33
  vpts_pkg::div_stage_t div_q [QB+1];
  vpts_pkg::div_stage_t div_init;

  always_comb begin
    logic [vpts_pkg::MagWidth-vpts_pkg::LowBits-1:0] hi;
    div_init.dm   = dm_q;
    div_init.winv = winv_q;
    for (int i = 0; i < 3; i++) begin
      hi = nm_q[i][vpts_pkg::MagWidth-1:vpts_pkg::LowBits];
      div_init.lane[i].big  = (vpts_pkg::DivWidth'(hi) >= dm_q);
      div_init.lane[i].rem  = div_init.lane[i].big ? '0 : vpts_pkg::DivWidth'(hi);
      div_init.lane[i].quot = '0;
      div_init.lane[i].low  = nm_q[i][vpts_pkg::LowBits-1:0];
      div_init.lane[i].neg  = neg_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[DB]) div_q[0] <= div_init;
  end

  // ------------------------------------ divider: one quotient bit a stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv[DB+k+1]) div_q[k+1] <= vpts_pkg::div_step(div_q[k]);
    end
  end

  // ----------------------------------------------- viewport scale multiply
  logic [vpts_pkg::CapWidth-1:0]    mag_c [3];
  logic [vpts_pkg::ScaledWidth-1:0] scaled_q [2];
  logic [vpts_pkg::CapWidth-1:0]    mag_z_q;
  logic [2:0]                       mneg_q;
  logic                             mwinv_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = div_q[QB].lane[i].big ? {1'b1, {QB{1'b0}}}
                                       : {1'b0, div_q[QB].lane[i].quot};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[MS]) begin
      scaled_q[0] <= vpts_pkg::ScaledWidth'(mag_c[0]) * vpts_pkg::ScaledWidth'(scale_x_q);
      scaled_q[1] <= vpts_pkg::ScaledWidth'(mag_c[1]) * vpts_pkg::ScaledWidth'(scale_y_q);
      mag_z_q     <= mag_c[2];
      for (int i = 0; i < 3; i++) begin
        mneg_q[i] <= div_q[QB].lane[i].neg;
      end
      mwinv_q <= div_q[QB].winv;
    end
  end

  // ------------------------------------- offset, saturation, output register
  logic signed [vpts_pkg::ScrWidth-1:0] scr_c [2];
  logic signed [vpts_pkg::ScrWidth-1:0] dep_c;
  vpts_pkg::sat_res_t                   sx_c, sy_c, dz_c;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      scr_c[i] = signed'(vpts_pkg::ScrWidth'(scaled_q[i]));
      if (mneg_q[i]) scr_c[i] = -scr_c[i];
    end
    scr_c[0] = scr_c[0] + signed'(vpts_pkg::ScrWidth'({off_x_q, {vpts_pkg::CoordFrac{1'b0}}}));
    scr_c[1] = scr_c[1] + signed'(vpts_pkg::ScrWidth'({off_y_q, {vpts_pkg::CoordFrac{1'b0}}}));
    dep_c    = signed'(vpts_pkg::ScrWidth'(mag_z_q));
    if (mneg_q[2]) dep_c = -dep_c;
    sx_c = vpts_pkg::sat_coord(scr_c[0]);
    sy_c = vpts_pkg::sat_coord(scr_c[1]);
    dz_c = vpts_pkg::sat_coord(dep_c);
  end

  logic signed [vpts_pkg::CoordWidth-1:0] sx_q, sy_q, dz_q;
  logic                                   winv_out_q, sat_out_q;

  // zero w forces zeros and a clear saturation flag
  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      sx_q       <= mwinv_q ? '0 : sx_c.val;
      sy_q       <= mwinv_q ? '0 : sy_c.val;
      dz_q       <= mwinv_q ? '0 : dz_c.val;
      winv_out_q <= mwinv_q;
      sat_out_q  <= !mwinv_q && (sx_c.sat || sy_c.sat || dz_c.sat);
    end
  end

  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign depth_o     = dz_q;
  assign w_invalid_o = winv_out_q;
  assign saturated_o = sat_out_q;

endmodule

### tb/vpts_checker.sv
module vpts_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic                                   pready,
  input  logic [vpts_pkg::CfgAddrWidth-1:0]      paddr,
  input  logic [vpts_pkg::CfgDataWidth-1:0]      pwdata,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_o,
  input  logic signed [vpts_pkg::CoordWidth-1:0] coord_x_i,
  input  logic signed [vpts_pkg::CoordWidth-1:0] coord_y_i,
  input  logic signed [vpts_pkg::CoordWidth-1:0] coord_z_i,
  input  logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  logic signed [vpts_pkg::CoordWidth-1:0] screen_x_o,
  input  logic signed [vpts_pkg::CoordWidth-1:0] screen_y_o,
  input  logic signed [vpts_pkg::CoordWidth-1:0] depth_o,
  input  logic                                   w_invalid_o,
  input  logic                                   saturated_o,
  output int unsigned                            errors_o,
  output int unsigned                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint AccLim = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned QuotCap = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [vpts_pkg::CoordWidth-1:0] sx;
    logic signed [vpts_pkg::CoordWidth-1:0] sy;
    logic signed [vpts_pkg::CoordWidth-1:0] dz;
    logic                                   winv;
    logic                                   sat;
  } screen_res_t;

  logic [63:0] mrow [4];
  logic [15:0] offs_x, offs_y, scl_x, scl_y;
  screen_res_t screen_q [$];

  assign pending_o = screen_q.size();

  function automatic longint clamp_acc(input longint v, inout bit sat);
    if (v > AccLim) begin
      sat = 1;
      return AccLim;
    end
    if (v < -AccLim) begin
      sat = 1;
      return -AccLim;
    end
    return v;
  endfunction

  function automatic longint clamp_coord(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // (c + w) / 2w in Q16.16, truncated, magnitude capped
  function automatic void norm_ratio(input longint c, input longint w,
                                     output bit neg, output longint unsigned mag);
    longint            n;
    longint unsigned   nm, dm;
    logic [127:0]      num, quo;
    n   = c + w;
    nm  = (n < 0) ? -n : n;
    dm  = (w < 0) ? -w : w;
    num = {64'd0, nm} << 15;
    quo = num / {64'd0, dm};
    mag = (quo > {64'd0, QuotCap}) ? QuotCap : quo[63:0];
    neg = (n < 0) != (w < 0);
  endfunction

  function automatic longint to_pixels(input bit neg, input longint unsigned mag,
                                       input logic [15:0] scale, input logic [15:0] offset,
                                       inout bit sat);
    longint sc, q;
    sc = {48'd0, scale};
    q  = neg ? -longint'(mag) : longint'(mag);
    if (scale != 0 && mag > QuotCap / {48'd0, scale})
      return clamp_coord(neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF, sat);
    return clamp_coord(q * sc + (longint'({48'd0, offset}) <<< 16), sat);
  endfunction

  function automatic screen_res_t project_vertex(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
    screen_res_t     res;
    longint          v [4];
    longint          clip [4];
    longint          acc, ent;
    bit              sat, neg;
    longint unsigned mag;
    sat  = 0;
    v[0] = longint'(x);
    v[1] = longint'(y);
    v[2] = longint'(z);
    v[3] = 64'sd65536;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        ent = longint'($signed(mrow[r][16*j +: 16]));
        acc = clamp_acc(acc + clamp_acc(ent * v[j], sat), sat);
      end
      clip[r] = acc;
    end
    res = '0;
    // degenerate w: flag only, everything else zero
    if (clip[3] == 0) begin
      res.winv = 1;
      return res;
    end
    norm_ratio(clip[0], clip[3], neg, mag);
    res.sx = vpts_pkg::CoordWidth'(to_pixels(neg, mag, scl_x, offs_x, sat));
    norm_ratio(clip[1], clip[3], neg, mag);
    res.sy = vpts_pkg::CoordWidth'(to_pixels(neg, mag, scl_y, offs_y, sat));
    norm_ratio(clip[2], clip[3], neg, mag);
    res.dz = vpts_pkg::CoordWidth'(clamp_coord(neg ? -longint'(mag) : longint'(mag), sat));
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrow[0] <= 64'h0000_0000_0000_1000;
      mrow[1] <= 64'h0000_0000_1000_0000;
      mrow[2] <= 64'h0000_1000_0000_0000;
      mrow[3] <= 64'h1000_0000_0000_0000;
      offs_x <= '0;
      offs_y <= '0;
      scl_x <= '0;
      scl_y <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (vpts_pkg::reg_idx_e'(paddr[5:3]))
        vpts_pkg::RegRow0:    mrow[0] <= pwdata;
        vpts_pkg::RegRow1:    mrow[1] <= pwdata;
        vpts_pkg::RegRow2:    mrow[2] <= pwdata;
        vpts_pkg::RegRow3:    mrow[3] <= pwdata;
        vpts_pkg::RegOffsetX: offs_x <= pwdata[15:0];
        vpts_pkg::RegOffsetY: offs_y <= pwdata[15:0];
        vpts_pkg::RegScaleX:  scl_x <= pwdata[15:0];
        vpts_pkg::RegScaleY:  scl_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  initial errors_o = 0;

  always @(posedge clk_i) begin
    screen_res_t seen, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        screen_q.push_back(project_vertex(coord_x_i, coord_y_i, coord_z_i));
      if (out_valid_o && out_ready_i) begin
        seen = '{screen_x_o, screen_y_o, depth_o, w_invalid_o, saturated_o};
        if (screen_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, seen);
          errors_o <= errors_o + 1;
        end else begin
          want = screen_q.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch sx exp %h got %h, sy exp %h got %h, dz exp %h got %h",
                     $realtime, want.sx, seen.sx, want.sy, seen.sy, want.dz, seen.dz);
            $display("%0t:   w_invalid exp %b got %b, saturated exp %b got %b",
                     $realtime, want.winv, seen.winv, want.sat, seen.sat);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_vertex_project_to_screen.sv
module tb_vertex_project_to_screen;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;

  logic                                    clk_i, rst_ni;
  logic                                    psel, penable, pwrite, pready;
  logic [vpts_pkg::CfgAddrWidth-1:0]       paddr;
  logic [vpts_pkg::CfgDataWidth-1:0]       pwdata, prdata;
  logic                                    in_valid_i, in_ready_o;
  logic signed [vpts_pkg::CoordWidth-1:0]  coord_x_i, coord_y_i, coord_z_i;
  logic                                    out_valid_o, out_ready_i;
  logic signed [vpts_pkg::CoordWidth-1:0]  screen_x_o, screen_y_o, depth_o;
  logic                                    w_invalid_o, saturated_o;
  int unsigned                             errors, pending;
  int unsigned                             vertex_cnt, setup_cnt, stall_cnt;
  bit                                      calm;

  vertex_project_to_screen DUT (.*);

  vpts_checker u_checker (
    .errors_o (errors),
    .pending_o(pending),
    .*
  );

  // free-running clock
  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // result side back-pressure, switched off during the calm stretch
  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 14);
  end

  // watchdog: cycles with no request, result or register write moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $realtime, pending);
      $display("status: fail");
      $finish;
    end
  end

  // setup phase then access phase
  task automatic reg_write(input vpts_pkg::reg_idx_e idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vpts_pkg::CfgAddrWidth'(idx) << 3;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] pack_row(input logic [15:0] c0, input logic [15:0] c1,
                                           input logic [15:0] c2, input logic [15:0] c3);
    return {c3, c2, c1, c0};
  endfunction

  function automatic logic [63:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  // small signed entry, keeps w close to zero so quotients blow up
  function automatic logic [15:0] tiny_entry();
    return 16'($signed($urandom_range(8)) - 4);
  endfunction

  // mix of full-range, moderate and corner coordinates
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 ** 21)) - 2 ** 20);
      2: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return 32'($signed($urandom_range(2 ** 25)) - 2 ** 24);
    endcase
  endfunction

  // keep valid up until accepted; idle gaps only ahead of a new request
  task automatic push_vertex(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    vertex_cnt++;
  endtask

  // let the pipe drain before touching the registers
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // load one viewport setup; kind picks the flavour
  task automatic load_setup(input int kind);
    logic [63:0] r0, r1, r2, r3;
    logic [15:0] ox, oy, sx, sy;
    r0 = rand_row();
    r1 = rand_row();
    r2 = rand_row();
    r3 = rand_row();
    ox = 16'($urandom);
    oy = 16'($urandom);
    sx = 16'($urandom);
    sy = 16'($urandom);
    case (kind)
      // identity with the widest viewport
      1: begin
        r0 = pack_row(16'h1000, 16'h0, 16'h0, 16'h0);
        r1 = pack_row(16'h0, 16'h1000, 16'h0, 16'h0);
        r2 = pack_row(16'h0, 16'h0, 16'h1000, 16'h0);
        r3 = pack_row(16'h0, 16'h0, 16'h0, 16'h1000);
        ox = 16'hFFFF;
        oy = 16'hFFFF;
        sx = 16'hFFFF;
        sy = 16'hFFFF;
      end
      // perspective style: w = -z, so z of zero gives a degenerate w
      2: begin
        r0 = pack_row(16'h1800, 16'h0, 16'h0, 16'h0);
        r1 = pack_row(16'h0, 16'h2000, 16'h0, 16'h0);
        r2 = pack_row(16'h0, 16'h0, 16'hE000, 16'hF000);
        r3 = pack_row(16'h0, 16'h0, 16'hF000, 16'h0);
        ox = 16'd320;
        oy = 16'd240;
        sx = 16'd640;
        sy = 16'd480;
      end
      // largest positive entries
      3: begin
        r0 = {4{16'h7FFF}};
        r1 = {4{16'h7FFF}};
        r2 = {4{16'h7FFF}};
        r3 = {4{16'h7FFF}};
      end
      // most negative entries, zero viewport
      4: begin
        r0 = {4{16'h8000}};
        r1 = {4{16'h8000}};
        r2 = {4{16'h8000}};
        r3 = {4{16'h8000}};
        ox = '0;
        oy = '0;
        sx = '0;
        sy = '0;
      end
      // w row all zero: every vertex flagged
      5: r3 = '0;
      // tiny w row for huge quotients
      6: r3 = pack_row(tiny_entry(), tiny_entry(), tiny_entry(), tiny_entry());
      // huge quotients with zero scale: screen is just the offset
      7: begin
        r3 = pack_row(tiny_entry(), tiny_entry(), tiny_entry(), tiny_entry());
        sx = '0;
        sy = '0;
      end
      default: ;
    endcase
    reg_write(vpts_pkg::RegRow0, r0);
    reg_write(vpts_pkg::RegRow1, r1);
    reg_write(vpts_pkg::RegRow2, r2);
    reg_write(vpts_pkg::RegRow3, r3);
    reg_write(vpts_pkg::RegOffsetX, {48'd0, ox});
    reg_write(vpts_pkg::RegOffsetY, {48'd0, oy});
    reg_write(vpts_pkg::RegScaleX, {48'd0, sx});
    reg_write(vpts_pkg::RegScaleY, {48'd0, sy});
    setup_cnt++;
  endtask

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    coord_x_i   = '0;
    coord_y_i   = '0;
    coord_z_i   = '0;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    vertex_cnt  = 0;
    setup_cnt   = 0;
    stall_cnt   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setup, corners under the widest viewport, perspective, then zero scale
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    drain();
    load_setup(1);
    push_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    push_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    load_setup(2);
    push_vertex(32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
    push_vertex(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();
    load_setup(7);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);
    push_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    drain();

    // random phases, each under a fresh setup; phase 4 runs without any idling
    for (int ph = 0; ph < 14; ph++) begin
      load_setup(ph % 8);
      calm = (ph == 4);
      repeat (31) push_vertex(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    calm = 1'b0;

    repeat (50) @(posedge clk_i);
    $display("projected %0d vertices across %0d viewport setups", vertex_cnt, setup_cnt);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
